>>> src/utf8d_pkg.sv
// shared types and constants for the utf-8 code point decoder
// no dependencies

package utf8d_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [20:0] REPL_CP = 21'h00FFFD;

  localparam logic [7:0] MASK_CONT_TAG = 8'hC0;
  localparam logic [7:0] CONT_TAG      = 8'h80;
  localparam logic [7:0] MASK_CONT_VAL = 8'h3F;
  localparam logic [7:0] MASK_LEAD2    = 8'hE0;
  localparam logic [7:0] TAG_LEAD2     = 8'hC0;
  localparam logic [7:0] MASK_LEAD3    = 8'hF0;
  localparam logic [7:0] TAG_LEAD3     = 8'hE0;
  localparam logic [7:0] MASK_LEAD4    = 8'hF8;
  localparam logic [7:0] TAG_LEAD4     = 8'hF0;
  localparam logic [7:0] VAL_LEAD2     = 8'h1F;
  localparam logic [7:0] VAL_LEAD3     = 8'h0F;
  localparam logic [7:0] VAL_LEAD4     = 8'h07;

  // one run of results caused by one input byte
  typedef struct packed {
    logic [1:0]  n_repl;
    logic        has_tail;
    logic [20:0] cp;
    logic        tail_repl;
    logic        tail_end;
    logic [2:0]  tail_used;
  } run_t;

endpackage

>>> src/utf8d_front.sv
// front end: accepts bytes, tracks the open sequence and classifies each byte
// into a run descriptor; depends on utf8d_pkg

module utf8d_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        byte_in,
  output logic              push,
  output utf8d_pkg::run_t   run
);

  logic [20:0] pv_r, pv_nxt;
  logic [1:0]  exp_r, exp_nxt;
  logic [1:0]  taken_r, taken_nxt;

  logic [2:0]  taken_inc;
  logic [20:0] pv_cont;
  logic        is_cont;

  always_comb begin
    is_cont   = (byte_in & utf8d_pkg::MASK_CONT_TAG) == utf8d_pkg::CONT_TAG;
    taken_inc = {1'b0, taken_r} + 3'd1;
    pv_cont   = {pv_r[14:0], byte_in[5:0] & utf8d_pkg::MASK_CONT_VAL[5:0]};

    pv_nxt    = pv_r;
    exp_nxt   = exp_r;
    taken_nxt = taken_r;

    run           = '0;
    run.n_repl    = 2'd0;
    run.has_tail  = 1'b0;

    if (exp_r != 2'd0 && is_cont) begin
      pv_nxt    = pv_cont;
      taken_nxt = taken_inc[1:0];
      if (taken_inc >= {1'b0, exp_r}) begin
        run.has_tail  = 1'b1;
        run.cp        = pv_cont;
        run.tail_used = {1'b0, exp_r} + 3'd1;
        pv_nxt        = '0;
        exp_nxt       = 2'd0;
        taken_nxt     = 2'd0;
      end
    end else begin
      // broken sequence: lead plus taken continuations become replacements
      if (exp_r != 2'd0) begin
        run.n_repl = (taken_r >= 2'd2) ? 2'd3 : taken_r + 2'd1;
      end
      pv_nxt    = '0;
      exp_nxt   = 2'd0;
      taken_nxt = 2'd0;
      if (byte_in == 8'd0) begin
        run.has_tail  = 1'b1;
        run.cp        = '0;
        run.tail_end  = 1'b1;
        run.tail_used = 3'd0;
      end else if (!byte_in[7]) begin
        run.has_tail  = 1'b1;
        run.cp        = {13'd0, byte_in};
        run.tail_used = 3'd1;
      end else if ((byte_in & utf8d_pkg::MASK_LEAD2) == utf8d_pkg::TAG_LEAD2) begin
        exp_nxt = 2'd1;
        pv_nxt  = {13'd0, byte_in & utf8d_pkg::VAL_LEAD2};
      end else if ((byte_in & utf8d_pkg::MASK_LEAD3) == utf8d_pkg::TAG_LEAD3) begin
        exp_nxt = 2'd2;
        pv_nxt  = {13'd0, byte_in & utf8d_pkg::VAL_LEAD3};
      end else if ((byte_in & utf8d_pkg::MASK_LEAD4) == utf8d_pkg::TAG_LEAD4) begin
        exp_nxt = 2'd3;
        pv_nxt  = {13'd0, byte_in & utf8d_pkg::VAL_LEAD4};
      end else begin
        run.has_tail  = 1'b1;
        run.cp        = utf8d_pkg::REPL_CP;
        run.tail_repl = 1'b1;
        run.tail_used = 3'd1;
      end
    end

    push = acc && (run.n_repl != 2'd0 || run.has_tail);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r    <= '0;
      exp_r   <= 2'd0;
      taken_r <= 2'd0;
    end else if (acc) begin
      pv_r    <= pv_nxt;
      exp_r   <= exp_nxt;
      taken_r <= taken_nxt;
    end
  end

endmodule

>>> src/utf8d_queue.sv
// small fifo of run descriptors between front and back end
// depends on utf8d_pkg

module utf8d_queue #(
  parameter int unsigned DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  utf8d_pkg::run_t   wr_data,
  input  logic              pop,
  output utf8d_pkg::run_t   rd_data,
  output logic              full,
  output logic              empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  utf8d_pkg::run_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = cnt_r == CW'(DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

>>> src/utf8d_back.sv
// back end: expands run descriptors into result transfers in the output
// register, one per cycle while the receiver is ready; depends on utf8d_pkg

module utf8d_back (
  input  logic              clk,
  input  logic              rst_n,
  input  utf8d_pkg::run_t   head,
  input  logic              head_valid,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [20:0]       out_code_point,
  output logic              out_is_replacement,
  output logic              out_end_of_text,
  output logic [2:0]        out_bytes_used,
  output logic              out_last_of_run
);

  logic [1:0]  idx_r, idx_nxt;
  logic        valid_r;
  logic [20:0] cp_r, cp_nxt;
  logic        repl_r, repl_nxt;
  logic        end_r, end_nxt;
  logic [2:0]  used_r, used_nxt;
  logic        last_r, last_nxt;
  logic        load, in_repl;

  always_comb begin
    load    = head_valid && (!valid_r || out_ready);
    in_repl = idx_r < head.n_repl;
    if (in_repl) begin
      cp_nxt   = utf8d_pkg::REPL_CP;
      repl_nxt = 1'b1;
      end_nxt  = 1'b0;
      used_nxt = 3'd1;
      last_nxt = (idx_r == head.n_repl - 2'd1) && !head.has_tail;
    end else begin
      cp_nxt   = head.cp;
      repl_nxt = head.tail_repl;
      end_nxt  = head.tail_end;
      used_nxt = head.tail_used;
      last_nxt = 1'b1;
    end
    pop     = load && last_nxt;
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = last_nxt ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cp_r   <= cp_nxt;
      repl_r <= repl_nxt;
      end_r  <= end_nxt;
      used_r <= used_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid          = valid_r;
  assign out_code_point     = cp_r;
  assign out_is_replacement = repl_r;
  assign out_end_of_text    = end_r;
  assign out_bytes_used     = used_r;
  assign out_last_of_run    = last_r;

endmodule

>>> src/utf8_codepoint_decoder_core.sv
// top level of the utf-8 code point decoder
// depends on utf8d_pkg, utf8d_front, utf8d_queue, utf8d_back
//
// input channel: one text byte per transfer on in_byte_in (in_valid/in_ready);
// a zero byte ends the text, gives an end result and clears the decoder.
// result channel: out_valid/out_ready with code point, replacement flag,
// end flag, bytes used and a last flag on the final result of each byte.
// a byte yields zero to four results; lead and inner continuation bytes
// yield none, a broken sequence yields replacements then the fresh decode.
// a byte's run is written into the queue at the accepting edge; the back end
// then loads each result into the output register that drives out_valid.
// the front end takes one byte per cycle while in_ready is high; the back
// end emits one result per cycle unless out_ready stalls it, so bytes with
// several results are absorbed by a QUEUE_DEPTH entry run queue between the
// front and back end. in_ready drops only when that queue is full.
// reset (rst_n low, synchronous) clears the sequence state, queue and
// output register. when the receiver stalls the output register holds,
// the queue fills and in_ready then falls until results drain.

module utf8_codepoint_decoder_core #(
  parameter int unsigned QUEUE_DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_code_point,
  output logic        out_is_replacement,
  output logic        out_end_of_text,
  output logic [2:0]  out_bytes_used,
  output logic        out_last_of_run
);

  utf8d_pkg::run_t run, head;
  logic push, pop, full, empty, acc;

  assign in_ready = !full;
  assign acc      = in_valid && in_ready;

  utf8d_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .byte_in (in_byte_in),
    .push    (push),
    .run     (run)
  );

  utf8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (run),
    .pop     (pop),
    .rd_data (head),
    .full    (full),
    .empty   (empty)
  );

  utf8d_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .head_valid         (!empty),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_code_point     (out_code_point),
    .out_is_replacement (out_is_replacement),
    .out_end_of_text    (out_end_of_text),
    .out_bytes_used     (out_bytes_used),
    .out_last_of_run    (out_last_of_run)
  );

endmodule
